FILE: sv/ffra_pkg.sv
// Shared constants, types and codes of the first-fit range allocator.
package ffra_pkg;

  localparam int MAX_RANGES  = 16;
  localparam int OFFSET_BITS = 20;
  localparam int SIZE_W      = 21;
  localparam int OUT_OFF_W   = 20;
  localparam int IDX_W       = $clog2(MAX_RANGES);
  localparam int CNT_W       = $clog2(MAX_RANGES + 1);
  localparam int WIDE_W      = (OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W;
  localparam int SUM_W       = WIDE_W + 2;
  localparam int BUF_RESET   = 4096;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_EV,
    S_INS_RD,
    S_INS_WR,
    S_NEW_WR,
    S_REL_RD,
    S_REL_EV,
    S_DEL_RD,
    S_DEL_WR
  } fsm_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] start;
    logic [SIZE_W-1:0]      length;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } ram_req_t;

endpackage

FILE: sv/ffra_table_ram.sv
// Range table storage: one write port, one read port, registered read data.
module ffra_table_ram
  import ffra_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rdata
);

  entry_t mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: sv/ffra_ctrl.sv
// Command sequencer: table walk, entry shifting and result words.
module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            command,
  input  logic [SIZE_W-1:0]     request_size,
  input  logic [OUT_OFF_W-1:0]  release_offset,
  input  sum_t                  limit,
  input  entry_t                rdata,
  output ram_req_t              req,
  output logic                  busy,
  output logic                  res_valid,
  output logic [2:0]            res_status,
  output logic [OUT_OFF_W-1:0]  res_grant_off,
  output logic                  wake
);

  fsm_t                  state, state_next;
  cnt_t                  idx, idx_next;
  cnt_t                  pos, pos_next;
  cnt_t                  count, count_next;
  sum_t                  head, head_next;
  sum_t                  limit_q, limit_q_next;
  logic [SIZE_W-1:0]     size_q, size_q_next;
  logic [OUT_OFF_W-1:0]  offset_q, offset_q_next;
  logic                  wake_next;
  logic                  res_valid_next;
  status_t               res_status_next;
  logic [OUT_OFF_W-1:0]  res_grant_off_next;

  logic                  accept;
  cmd_t                  cmd_in;
  logic [SIZE_W-1:0]     size_eff;
  sum_t                  size_in_ext, size_ext;
  sum_t                  ent_start, ent_end;
  logic                  gap_fits, past_limit, last_entry, offset_hit, more_to_move;
  cnt_t                  idx_inc, idx_dec;

  assign accept      = start && !busy;
  assign cmd_in      = cmd_t'(command);
  assign size_eff    = (request_size == '0) ? SIZE_W'(1) : request_size;
  assign size_in_ext = SUM_W'(size_eff);
  assign size_ext    = SUM_W'(size_q);
  assign ent_start   = SUM_W'(rdata.start);
  assign ent_end     = ent_start + SUM_W'(rdata.length);
  assign gap_fits    = (head + size_ext) <= ent_start;
  assign past_limit  = (ent_end + size_ext) > limit_q;
  assign idx_inc     = idx + CNT_W'(1);
  assign idx_dec     = idx - CNT_W'(1);
  assign last_entry  = idx_inc == count;
  assign offset_hit  = ent_start == SUM_W'(offset_q);
  assign more_to_move = idx_inc < count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_ALLOC: begin
              if (size_in_ext > limit || count == CNT_W'(MAX_RANGES)) begin
                state_next = S_IDLE;
              end else if (count == '0) begin
                state_next = S_NEW_WR;
              end else begin
                state_next = S_ALLOC_RD;
              end
            end
            CMD_RELEASE: state_next = (count == '0) ? S_IDLE : S_REL_RD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC_RD: state_next = S_ALLOC_EV;
      S_ALLOC_EV: begin
        if (gap_fits)        state_next = S_INS_RD;
        else if (past_limit) state_next = S_IDLE;
        else if (last_entry) state_next = S_NEW_WR;
        else                 state_next = S_ALLOC_RD;
      end
      S_INS_RD: state_next = S_INS_WR;
      S_INS_WR: state_next = (idx_dec == pos) ? S_NEW_WR : S_INS_RD;
      S_NEW_WR: state_next = S_IDLE;
      S_REL_RD: state_next = S_REL_EV;
      S_REL_EV: begin
        if (offset_hit)      state_next = S_DEL_RD;
        else if (last_entry) state_next = S_IDLE;
        else                 state_next = S_REL_RD;
      end
      S_DEL_RD: state_next = more_to_move ? S_DEL_WR : S_IDLE;
      S_DEL_WR: state_next = S_DEL_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and result words
  always_comb begin
    idx_next           = idx;
    pos_next           = pos;
    count_next         = count;
    head_next          = head;
    limit_q_next       = limit_q;
    size_q_next        = size_q;
    offset_q_next      = offset_q;
    wake_next          = wake;
    res_valid_next     = 1'b0;
    res_status_next    = ST_GRANTED;
    res_grant_off_next = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          size_q_next   = size_eff;
          offset_q_next = release_offset;
          limit_q_next  = limit;
          head_next     = '0;
          idx_next      = '0;
          pos_next      = '0;
          case (cmd_in)
            CMD_ALLOC: begin
              if (size_in_ext > limit) begin
                res_valid_next  = 1'b1;
                res_status_next = ST_TOO_LARGE;
              end else if (count == CNT_W'(MAX_RANGES)) begin
                wake_next       = 1'b1;
                res_valid_next  = 1'b1;
                res_status_next = ST_NO_SPACE;
              end
            end
            CMD_RELEASE: begin
              if (count == '0) begin
                res_valid_next  = 1'b1;
                res_status_next = ST_UNKNOWN;
              end
            end
            CMD_CLEAR: begin
              count_next      = '0;
              res_valid_next  = 1'b1;
              res_status_next = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_ALLOC_EV: begin
        if (gap_fits) begin
          pos_next = idx;
          idx_next = count;
        end else if (past_limit) begin
          wake_next       = 1'b1;
          res_valid_next  = 1'b1;
          res_status_next = ST_NO_SPACE;
        end else begin
          head_next = ent_end;
          idx_next  = idx_inc;
          if (last_entry) pos_next = count;
        end
      end
      S_INS_WR: idx_next = idx_dec;
      S_NEW_WR: begin
        count_next         = count + CNT_W'(1);
        res_valid_next     = 1'b1;
        res_status_next    = ST_GRANTED;
        res_grant_off_next = head[OUT_OFF_W-1:0];
      end
      S_REL_EV: begin
        if (!offset_hit) begin
          idx_next = idx_inc;
          if (last_entry) begin
            res_valid_next  = 1'b1;
            res_status_next = ST_UNKNOWN;
          end
        end
      end
      S_DEL_RD: begin
        if (!more_to_move) begin
          count_next      = count - CNT_W'(1);
          wake_next       = 1'b0;
          res_valid_next  = 1'b1;
          res_status_next = ST_RELEASED;
        end
      end
      S_DEL_WR: idx_next = idx_inc;
      default: ;
    endcase
  end

  // memory port and handshake
  always_comb begin
    req.we    = 1'b0;
    req.waddr = idx[IDX_W-1:0];
    req.wdata = rdata;
    req.raddr = idx[IDX_W-1:0];
    busy      = state != S_IDLE;
    case (state)
      S_INS_RD: req.raddr = idx_dec[IDX_W-1:0];
      S_INS_WR: req.we    = 1'b1;
      S_NEW_WR: begin
        req.we          = 1'b1;
        req.waddr       = pos[IDX_W-1:0];
        req.wdata.start = head[OFFSET_BITS-1:0];
        req.wdata.length = size_q;
      end
      S_DEL_RD: req.raddr = idx_inc[IDX_W-1:0];
      S_DEL_WR: req.we    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wake      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      wake      <= wake_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx           <= idx_next;
    pos           <= pos_next;
    head          <= head_next;
    limit_q       <= limit_q_next;
    size_q        <= size_q_next;
    offset_q      <= offset_q_next;
    res_status    <= res_status_next;
    res_grant_off <= res_grant_off_next;
  end

endmodule

FILE: sv/first_fit_range_allocator_unit.sv
// Top level of the first-fit range allocator: config register, table, sequencer.
//
//  channel   | handshake               | word
//  ----------+-------------------------+---------------------------------------------
//  command   | start / busy            | command, request_size, release_offset
//  result    | done (one-cycle strobe) | status, granted_offset, waiter_flag
//  config    | buffer_size_we          | buffer_size_wdata (21 bits)
//
// One command word at a time. The table lives in a 16-entry RAM with
// registered read data; every entry visited or moved is read, then evaluated
// or written back. Clear, refusals of an oversized request or on a full table,
// and release on an empty table are answered from idle without raising busy;
// allocate and release may walk or shift the whole table. busy is high from the cycle after
// accept until the result strobe; done may coincide with the next accept.
// Synchronous reset empties the table, clears the waiter flag and loads
// buffer_size with 4096. The result receiver cannot stall the block.
module first_fit_range_allocator_unit
  import ffra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command,
  input  logic [SIZE_W-1:0]     request_size,
  input  logic [OUT_OFF_W-1:0]  release_offset,
  output logic                  done,
  output logic [2:0]            status,
  output logic [OUT_OFF_W-1:0]  granted_offset,
  output logic                  waiter_flag,
  input  logic                  buffer_size_we,
  input  logic [SIZE_W-1:0]     buffer_size_wdata
);

  // Usable space is the buffer size capped at the offset range.
  localparam sum_t OFFSET_CAP = SUM_W'(1) << OFFSET_BITS;

  logic [SIZE_W-1:0] buffer_size;
  sum_t              buf_ext;
  sum_t              limit;
  ram_req_t          req;
  entry_t            rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= SIZE_W'(BUF_RESET);
    end else if (buffer_size_we) begin
      buffer_size <= buffer_size_wdata;
    end
  end

  assign buf_ext = SUM_W'(buffer_size);
  assign limit   = (buf_ext > OFFSET_CAP) ? OFFSET_CAP : buf_ext;

  ffra_table_ram u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Sequencer: latches the word on accept, walks the sorted table, shifts
  // entries to open or close a slot, and emits one result word per alloc, release or clear command.
  ffra_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .command        (command),
    .request_size   (request_size),
    .release_offset (release_offset),
    .limit          (limit),
    .rdata          (rdata),
    .req            (req),
    .busy           (busy),
    .res_valid      (done),
    .res_status     (status),
    .res_grant_off  (granted_offset),
    .wake           (waiter_flag)
  );

endmodule
